/* hw/rtl/two_wire_humidity_sensor_master_assert.svh */
`ifndef TWO_WIRE_HUMIDITY_SENSOR_MASTER_ASSERT_SVH
`define TWO_WIRE_HUMIDITY_SENSOR_MASTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TWHSM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication into the following cycle.
`define TWHSM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/twhsm_pkg.sv */
package twhsm_pkg;

   localparam int unsigned HALF_W = 8;
   localparam int unsigned POLL_W = 16;
   localparam int unsigned TOUT_W = 8;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned MEAS_W = 16;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_POLL_INTERVAL = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT = 2'd2;

   localparam logic [HALF_W-1:0] HALF_RESET = 8'd4;
   localparam logic [POLL_W-1:0] POLL_RESET = 16'd3000;
   localparam logic [TOUT_W-1:0] TOUT_RESET = 8'd240;

   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_TEMP = 2'd1;
   localparam logic [1:0] CMD_HUMI = 2'd2;
   localparam logic [1:0] CMD_SOFT_RESET = 2'd3;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_NO_ACK = 2'd1;
   localparam logic [1:0] STAT_TIMEOUT = 2'd2;

   localparam logic [7:0] BYTE_TEMP = 8'h03;
   localparam logic [7:0] BYTE_HUMI = 8'h05;
   localparam logic [7:0] BYTE_RESET = 8'h1e;

   // Number of clock pulses with data high that precede a soft reset.
   localparam logic [3:0] RESET_CLOCKS = 4'd9;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'd0,
      ST_RST_LOW  = 4'd1,
      ST_RST_HIGH = 4'd2,
      ST_START0   = 4'd3,
      ST_START1   = 4'd4,
      ST_START2   = 4'd5,
      ST_START3   = 4'd6,
      ST_START4   = 4'd7,
      ST_START5   = 4'd8,
      ST_PUT_LOW  = 4'd9,
      ST_PUT_HIGH = 4'd10,
      ST_WAIT     = 4'd11,
      ST_GET_LOW  = 4'd12,
      ST_GET_HIGH = 4'd13
   } state_type;

   typedef struct packed {
      logic [HALF_W-1:0] half_period_ticks;
      logic [POLL_W-1:0] poll_interval_ticks;
      logic [TOUT_W-1:0] timeout_polls;
   } cfg_type;

   typedef struct packed {
      logic [MEAS_W-1:0] measurement;
      logic [1:0]        status;
      logic              done_res;
      logic              busy_res;
      logic              data_drive_enable;
      logic              data_out;
      logic              clock_out;
   } res_type;

endpackage

/* hw/rtl/twhsm_csr.sv */
module twhsm_csr import twhsm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [HALF_W-1:0] half_ff, half_in;
   logic [POLL_W-1:0] poll_ff, poll_in;
   logic [TOUT_W-1:0] tout_ff, tout_in;

   always_comb begin
      half_in = half_ff;
      poll_in = poll_ff;
      tout_in = tout_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_HALF_PERIOD:   half_in = csr_wdata[HALF_W-1:0];
            CSR_POLL_INTERVAL: poll_in = csr_wdata[POLL_W-1:0];
            CSR_TIMEOUT:       tout_in = csr_wdata[TOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_RESET;
         poll_ff <= POLL_RESET;
         tout_ff <= TOUT_RESET;
      end else begin
         half_ff <= half_in;
         poll_ff <= poll_in;
         tout_ff <= tout_in;
      end
   end

   assign cfg.half_period_ticks   = half_ff;
   assign cfg.poll_interval_ticks = poll_ff;
   assign cfg.timeout_polls       = tout_ff;

endmodule

/* hw/rtl/twhsm_seq.sv */
module twhsm_seq import twhsm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [1:0] command,
   input  logic       data_line_in,
   input  cfg_type    cfg,
   output res_type    res
);

   state_type         state_ff, state_in;
   logic [1:0]        pend_ff, pend_in;
   logic [3:0]        bit_ff, bit_in;
   logic              byte_ff, byte_in;
   logic [7:0]        shift_ff, shift_in;
   logic [MEAS_W-1:0] result_ff, result_in;
   logic [POLL_W-1:0] tick_ff, tick_in;
   logic [TOUT_W-1:0] poll_ff, poll_in;

   logic [POLL_W-1:0] len;
   logic              phase_end;
   logic [3:0]        bit_inc;
   logic [TOUT_W-1:0] poll_inc;
   logic [TOUT_W-1:0] poll_lim;
   logic              done;
   logic [1:0]        status;
   logic [MEAS_W-1:0] meas;
   logic              clk_o, dout_o, den_o;

   always_comb begin
      len = (state_ff == ST_WAIT) ? cfg.poll_interval_ticks
                                  : {{(POLL_W-HALF_W){1'b0}}, cfg.half_period_ticks};
      if (len == '0) begin
         len = {{(POLL_W-1){1'b0}}, 1'b1};
      end
      phase_end = ({1'b0, tick_ff} + {{POLL_W{1'b0}}, 1'b1}) >= {1'b0, len};
      bit_inc   = bit_ff + 4'd1;
      poll_inc  = poll_ff + {{(TOUT_W-1){1'b0}}, 1'b1};
      poll_lim  = (cfg.timeout_polls == '0) ? {{(TOUT_W-1){1'b0}}, 1'b1} : cfg.timeout_polls;
   end

   // Pins of the phase in force at the start of the tick.
   always_comb begin
      clk_o  = 1'b0;
      dout_o = 1'b0;
      den_o  = 1'b0;
      case (state_ff)
         ST_RST_LOW, ST_START0: begin
            den_o  = 1'b1;
            dout_o = 1'b1;
         end
         ST_RST_HIGH, ST_START1, ST_START5: begin
            clk_o  = 1'b1;
            den_o  = 1'b1;
            dout_o = 1'b1;
         end
         ST_START2, ST_START4: begin
            clk_o = 1'b1;
            den_o = 1'b1;
         end
         ST_START3: den_o = 1'b1;
         ST_PUT_LOW, ST_PUT_HIGH: begin
            clk_o = (state_ff == ST_PUT_HIGH);
            if (bit_ff < BITS_PER_BYTE) begin
               den_o  = 1'b1;
               dout_o = shift_ff[7];
            end
         end
         ST_GET_LOW, ST_GET_HIGH: begin
            clk_o = (state_ff == ST_GET_HIGH);
            // Acknowledge low after the first byte, released high after the second.
            if (bit_ff >= BITS_PER_BYTE) begin
               den_o  = 1'b1;
               dout_o = byte_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      shift_in  = shift_ff;
      result_in = result_ff;
      tick_in   = tick_ff;
      poll_in   = poll_ff;
      done      = 1'b0;
      status    = STAT_OK;
      meas      = '0;
      if (step) begin
         if (state_ff == ST_IDLE) begin
            if (command != CMD_NONE) begin
               pend_in = command;
               bit_in  = 4'd0;
               byte_in = 1'b0;
               tick_in = '0;
               poll_in = '0;
               if (command == CMD_SOFT_RESET) begin
                  shift_in = BYTE_RESET;
                  state_in = ST_RST_LOW;
               end else begin
                  shift_in = (command == CMD_TEMP) ? BYTE_TEMP : BYTE_HUMI;
                  state_in = ST_START0;
               end
            end
         end else if (!phase_end) begin
            tick_in = tick_ff + {{(POLL_W-1){1'b0}}, 1'b1};
         end else begin
            tick_in = '0;
            case (state_ff)
               ST_RST_LOW: state_in = ST_RST_HIGH;
               ST_RST_HIGH: begin
                  if (bit_inc >= RESET_CLOCKS) begin
                     bit_in   = 4'd0;
                     state_in = ST_START0;
                  end else begin
                     bit_in   = bit_inc;
                     state_in = ST_RST_LOW;
                  end
               end
               ST_START0: state_in = ST_START1;
               ST_START1: state_in = ST_START2;
               ST_START2: state_in = ST_START3;
               ST_START3: state_in = ST_START4;
               ST_START4: state_in = ST_START5;
               ST_START5: begin
                  bit_in   = 4'd0;
                  state_in = ST_PUT_LOW;
               end
               ST_PUT_LOW: state_in = ST_PUT_HIGH;
               ST_PUT_HIGH: begin
                  if (bit_ff < BITS_PER_BYTE) begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     bit_in   = bit_inc;
                     state_in = ST_PUT_LOW;
                  end else if (data_line_in) begin
                     done   = 1'b1;
                     status = STAT_NO_ACK;
                  end else if (pend_ff == CMD_SOFT_RESET) begin
                     done = 1'b1;
                  end else begin
                     bit_in   = 4'd0;
                     poll_in  = '0;
                     state_in = ST_WAIT;
                  end
               end
               ST_WAIT: begin
                  if (!data_line_in) begin
                     bit_in   = 4'd0;
                     byte_in  = 1'b0;
                     shift_in = 8'd0;
                     state_in = ST_GET_LOW;
                  end else begin
                     poll_in = poll_inc;
                     if (poll_inc >= poll_lim) begin
                        done   = 1'b1;
                        status = STAT_TIMEOUT;
                     end
                  end
               end
               ST_GET_LOW: state_in = ST_GET_HIGH;
               ST_GET_HIGH: begin
                  if (bit_ff < BITS_PER_BYTE) begin
                     shift_in = {shift_ff[6:0], data_line_in};
                     bit_in   = bit_inc;
                     state_in = ST_GET_LOW;
                  end else if (!byte_ff) begin
                     result_in = {shift_ff, 8'd0};
                     byte_in   = 1'b1;
                     bit_in    = 4'd0;
                     shift_in  = 8'd0;
                     state_in  = ST_GET_LOW;
                  end else begin
                     result_in = {result_ff[15:8], shift_ff};
                     done      = 1'b1;
                     meas      = {result_ff[15:8], shift_ff};
                  end
               end
               default: state_in = ST_IDLE;
            endcase
            if (done) begin
               state_in = ST_IDLE;
               bit_in   = 4'd0;
               byte_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pend_ff   <= CMD_NONE;
         bit_ff    <= 4'd0;
         byte_ff   <= 1'b0;
         shift_ff  <= 8'd0;
         result_ff <= '0;
         tick_ff   <= '0;
         poll_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         bit_ff    <= bit_in;
         byte_ff   <= byte_in;
         shift_ff  <= shift_in;
         result_ff <= result_in;
         tick_ff   <= tick_in;
         poll_ff   <= poll_in;
      end
   end

   assign res.clock_out         = clk_o;
   assign res.data_out          = dout_o;
   assign res.data_drive_enable = den_o;
   assign res.busy_res          = (state_in != ST_IDLE);
   assign res.done_res          = done;
   assign res.status            = status;
   assign res.measurement       = meas;

endmodule

/* hw/rtl/two_wire_humidity_sensor_master.sv */
// Channel  Direction  Word bits  Contents (lowest bit first)
// req      in         8          command[1:0], data_line_in, zero fill
// rsp      out        24         clock_out, data_out, data_drive_enable, busy_res,
//                                done_res, status[1:0], measurement[15:0], zero fill
// csr      in         16         write only: half period, poll interval, timeout polls
//
// Each req word is one tick; one word is accepted and one rsp word produced per cycle
// while rsp is not stalled. The req word is registered, the sequencer steps on it, and the
// result lands in the rsp register. The sequencer state advances only when that register
// can take the result, so a stall on rsp holds the pipeline and drops req_tready.
// Reset is synchronous and returns the sequencer to idle with the csr registers at defaults.
module two_wire_humidity_sensor_master import twhsm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // command[1:0], data_line_in[2], zero [7:3]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // clock_out[0], data_out[1], data_drive_enable[2], busy_res[3], done_res[4],
   // status[6:5], measurement[22:7], zero [23]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   res_type res;

   logic       in_vld_ff, in_vld_in;
   logic [1:0] in_cmd_ff;
   logic       in_din_ff;
   logic       out_vld_ff, out_vld_in;
   res_type    out_res_ff;
   logic       out_free;
   logic       step;

   twhsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   twhsm_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .command      (in_cmd_ff),
      .data_line_in (in_din_ff),
      .cfg          (cfg),
      .res          (res)
   );

   assign out_free   = !out_vld_ff || rsp_tready;
   assign step       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || step;

   always_comb begin
      in_vld_in  = in_vld_ff;
      out_vld_in = out_vld_ff;
      if (req_tready) begin
         in_vld_in = req_tvalid;
      end
      if (out_free) begin
         out_vld_in = step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= req_tdata[1:0];
         in_din_ff <= req_tdata[2];
      end
      if (step) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_res_ff.measurement, out_res_ff.status,
                        out_res_ff.done_res, out_res_ff.busy_res,
                        out_res_ff.data_drive_enable, out_res_ff.data_out,
                        out_res_ff.clock_out};

endmodule

/* hw/rtl/twhsm_chk.sv */
`include "two_wire_humidity_sensor_master_assert.svh"

module twhsm_chk import twhsm_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result word keeps its contents.
   `TWHSM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")

   // When the result side can take a word, the request side is never stalled.
   `TWHSM_ASSERT_NOW(a_req_flow, !rsp_tvalid || rsp_tready, req_tready, "req stalled with rsp free")

   // A failed command reports no reading and ends the sequence.
   `TWHSM_ASSERT_NOW(a_err_done, rsp_tvalid && (rsp_tdata[6:5] != STAT_OK), rsp_tdata[4] && !rsp_tdata[3] && (rsp_tdata[22:7] == 16'd0), "error word malformed")

   // Outside a finishing word there is neither a status nor a reading.
   `TWHSM_ASSERT_NOW(a_idle_quiet, rsp_tvalid && !rsp_tdata[4], (rsp_tdata[6:5] == STAT_OK) && (rsp_tdata[22:7] == 16'd0), "status or reading without done")

endmodule

bind two_wire_humidity_sensor_master twhsm_chk u_twhsm_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
